[sv/pinhole_reprojection_jacobian_macros.svh]
// Assertion macros shared by the checker of the reprojection Jacobian block.
`ifndef PINHOLE_REPROJECTION_JACOBIAN_MACROS_SVH
`define PINHOLE_REPROJECTION_JACOBIAN_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PRJ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PRJ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/prj_pkg.sv]
// Shared types, constants and fixed-point helpers of the reprojection Jacobian block.
package prj_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int Q_W        = 32;
  localparam int DIV_NB     = Q_W + FRAC_BITS;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int IN_W       = 12 * Q_W;
  localparam int OUT_W      = 10 * Q_W;

  typedef logic signed [31:0] q_t;
  typedef logic signed [63:0] qw_t;

  localparam q_t  Q_MAX = 32'sh7fff_ffff;
  localparam q_t  Q_MIN = 32'sh8000_0000;
  localparam q_t  ONE_Q = q_t'(32'sd1 <<< FRAC_BITS);
  localparam qw_t ONE_W = qw_t'(ONE_Q);

  // Input transaction, last field in the lowest bits.
  typedef struct packed {
    q_t obs_v;
    q_t obs_u;
    q_t point_z;
    q_t point_y;
    q_t point_x;
    q_t trans_z;
    q_t trans_y;
    q_t trans_x;
    q_t quat_w;
    q_t quat_z;
    q_t quat_y;
    q_t quat_x;
  } prj_in_t;

  // One result row, last field in the lowest bits.
  typedef struct packed {
    q_t jac_pose_5;
    q_t jac_pose_4;
    q_t jac_pose_3;
    q_t jac_pose_2;
    q_t jac_pose_1;
    q_t jac_pose_0;
    q_t jac_point_2;
    q_t jac_point_1;
    q_t jac_point_0;
    q_t error_value;
  } prj_row_t;

  // Queue entry between the front and the back: rotation, observed pixel, camera-frame point.
  typedef struct packed {
    q_t [8:0] rot;
    q_t       obs_u;
    q_t       obs_v;
    q_t       pc_x;
    q_t       pc_y;
    q_t       pc_z;
  } prj_mid_t;

  // Side data that travels alongside the divider.
  typedef struct packed {
    q_t [8:0] rot;
    q_t       obs_u;
    q_t       obs_v;
    logic     zpos;
  } prj_dpay_t;

  // Queue status seen by the back.
  typedef struct packed {
    logic full;
    logic empty;
  } prj_qstat_t;

  function automatic qw_t widen(q_t a);
    return qw_t'(a);
  endfunction

  function automatic q_t sat(qw_t v);
    if (v > qw_t'(Q_MAX)) begin
      return Q_MAX;
    end else if (v < qw_t'(Q_MIN)) begin
      return Q_MIN;
    end
    return q_t'(v[31:0]);
  endfunction

  function automatic qw_t qprod(q_t a, q_t b);
    qw_t p;
    p = a * b;
    return p;
  endfunction

  // Product rescale: floor shift by the fraction width, then saturate.
  function automatic q_t qscale(qw_t p);
    qw_t s;
    s = p >>> FRAC_BITS;
    return sat(s);
  endfunction

  function automatic q_t qneg(q_t a);
    return sat(-widen(a));
  endfunction

  function automatic q_t fsig(logic [30:0] f);
    return q_t'({1'b0, f});
  endfunction

endpackage

[sv/prj_front.sv]
// Front part: rotation matrix from the quaternion and the camera-frame point.
module prj_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  prj_pkg::prj_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output prj_pkg::prj_mid_t out_item_o
);
  import prj_pkg::*;

  typedef struct packed {
    qw_t [8:0] prod;
    q_t  [2:0] t;
    q_t  [2:0] p;
    q_t        obs_u;
    q_t        obs_v;
  } f1_t;

  typedef struct packed {
    q_t [8:0] rot;
    q_t [2:0] t;
    q_t [2:0] p;
    q_t       obs_u;
    q_t       obs_v;
  } f2_t;

  typedef struct packed {
    qw_t [8:0] prod;
    q_t  [8:0] rot;
    q_t  [2:0] t;
    q_t        obs_u;
    q_t        obs_v;
  } f3_t;

  logic [3:0] v_q;
  logic       adv;
  f1_t        s1_q, s1_d;
  f2_t        s2_q, s2_d;
  f3_t        s3_q, s3_d;
  prj_mid_t   s4_q, s4_d;

  // The whole front moves together whenever its last stage can drain.
  assign adv         = !v_q[3] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = v_q[3];
  assign out_item_o  = s4_q;

  // Stage one: the nine quaternion products.
  always_comb begin
    s1_d.prod[0] = qprod(in_item_i.quat_x, in_item_i.quat_x);
    s1_d.prod[1] = qprod(in_item_i.quat_y, in_item_i.quat_y);
    s1_d.prod[2] = qprod(in_item_i.quat_z, in_item_i.quat_z);
    s1_d.prod[3] = qprod(in_item_i.quat_x, in_item_i.quat_y);
    s1_d.prod[4] = qprod(in_item_i.quat_x, in_item_i.quat_z);
    s1_d.prod[5] = qprod(in_item_i.quat_y, in_item_i.quat_z);
    s1_d.prod[6] = qprod(in_item_i.quat_x, in_item_i.quat_w);
    s1_d.prod[7] = qprod(in_item_i.quat_y, in_item_i.quat_w);
    s1_d.prod[8] = qprod(in_item_i.quat_z, in_item_i.quat_w);
    s1_d.t       = {in_item_i.trans_z, in_item_i.trans_y, in_item_i.trans_x};
    s1_d.p       = {in_item_i.point_z, in_item_i.point_y, in_item_i.point_x};
    s1_d.obs_u   = in_item_i.obs_u;
    s1_d.obs_v   = in_item_i.obs_v;
  end

  // Stage two: rescale the products and form the rotation matrix.
  always_comb begin
    q_t xx, yy, zz, xy, xz, yz, xw, yw, zw;
    xx = qscale(s1_q.prod[0]);
    yy = qscale(s1_q.prod[1]);
    zz = qscale(s1_q.prod[2]);
    xy = qscale(s1_q.prod[3]);
    xz = qscale(s1_q.prod[4]);
    yz = qscale(s1_q.prod[5]);
    xw = qscale(s1_q.prod[6]);
    yw = qscale(s1_q.prod[7]);
    zw = qscale(s1_q.prod[8]);
    s2_d.rot[0] = sat(ONE_W - ((widen(yy) + widen(zz)) <<< 1));
    s2_d.rot[1] = sat((widen(xy) - widen(zw)) <<< 1);
    s2_d.rot[2] = sat((widen(xz) + widen(yw)) <<< 1);
    s2_d.rot[3] = sat((widen(xy) + widen(zw)) <<< 1);
    s2_d.rot[4] = sat(ONE_W - ((widen(xx) + widen(zz)) <<< 1));
    s2_d.rot[5] = sat((widen(yz) - widen(xw)) <<< 1);
    s2_d.rot[6] = sat((widen(xz) - widen(yw)) <<< 1);
    s2_d.rot[7] = sat((widen(yz) + widen(xw)) <<< 1);
    s2_d.rot[8] = sat(ONE_W - ((widen(xx) + widen(yy)) <<< 1));
    s2_d.t      = s1_q.t;
    s2_d.p      = s1_q.p;
    s2_d.obs_u  = s1_q.obs_u;
    s2_d.obs_v  = s1_q.obs_v;
  end

  // Stage three: matrix times point, one product per element.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s3_d.prod[i*3+j] = qprod(s2_q.rot[i*3+j], s2_q.p[j]);
      end
    end
    s3_d.rot   = s2_q.rot;
    s3_d.t     = s2_q.t;
    s3_d.obs_u = s2_q.obs_u;
    s3_d.obs_v = s2_q.obs_v;
  end

  // Stage four: sum each row with the translation.
  always_comb begin
    q_t [2:0] pc;
    for (int i = 0; i < 3; i++) begin
      pc[i] = sat(widen(qscale(s3_q.prod[i*3])) + widen(qscale(s3_q.prod[i*3+1])) +
                  widen(qscale(s3_q.prod[i*3+2])) + widen(s3_q.t[i]));
    end
    s4_d.rot   = s3_q.rot;
    s4_d.obs_u = s3_q.obs_u;
    s4_d.obs_v = s3_q.obs_v;
    s4_d.pc_x  = pc[0];
    s4_d.pc_y  = pc[1];
    s4_d.pc_z  = pc[2];
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

endmodule

[sv/prj_fifo.sv]
// Short queue that decouples the front from the back.
module prj_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  prj_pkg::prj_mid_t   item_i,
  input  logic                pop_i,
  output prj_pkg::prj_mid_t   item_o,
  output prj_pkg::prj_qstat_t stat_o
);
  import prj_pkg::*;

  prj_mid_t           mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q, cnt_d;

  assign item_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  // Fill level follows pushes and pops.
  always_comb begin
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + (FIFO_AW+1)'(1);
      2'b01:   cnt_d = cnt_q - (FIFO_AW+1)'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + FIFO_AW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

[sv/prj_div.sv]
// Pipelined restoring divider, three lanes over one shared divisor, one bit per stage.
module prj_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               in_valid_i,
  input  prj_pkg::q_t [2:0]  num_i,
  input  prj_pkg::q_t        den_i,
  input  prj_pkg::prj_dpay_t pay_i,
  output logic               out_valid_o,
  output prj_pkg::q_t [2:0]  quo_o,
  output prj_pkg::prj_dpay_t pay_o
);
  import prj_pkg::*;

  localparam int NB = DIV_NB;
  localparam logic [NB-1:0] MAG_MAX = NB'(64'h7fff_ffff);
  localparam logic [NB-1:0] MAG_MIN = NB'(64'h8000_0000);

  typedef struct packed {
    logic [2:0][NB-1:0] nq;
    logic [2:0][31:0]   rem;
    logic [31:0]        d;
    logic [2:0]         neg;
    logic [2:0]         a_pos;
    logic [2:0]         a_neg;
    logic               bzero;
    prj_dpay_t          pay;
  } dst_t;

  dst_t      st_q [NB+1];
  dst_t      st_d [NB+1];
  logic [NB:0] sv_q;
  logic      ov_q;
  q_t [2:0]  quo_q, quo_d;
  prj_dpay_t pay_q;

  // One quotient bit for every lane.
  function automatic dst_t div_step(dst_t s);
    dst_t        r;
    logic [32:0] rem2;
    logic        ge;
    r = s;
    for (int l = 0; l < 3; l++) begin
      rem2      = {s.rem[l], s.nq[l][NB-1]};
      ge        = (rem2 >= {1'b0, s.d});
      r.rem[l]  = ge ? 32'(rem2 - {1'b0, s.d}) : rem2[31:0];
      r.nq[l]   = {s.nq[l][NB-2:0], ge};
    end
    return r;
  endfunction

  // Sign, saturation and the zero-divisor cases.
  function automatic q_t div_fix(logic [NB-1:0] nq, logic neg, logic a_pos, logic a_neg,
                                 logic bzero);
    if (bzero) begin
      return a_pos ? Q_MAX : (a_neg ? Q_MIN : q_t'(0));
    end else if (neg) begin
      return (nq > MAG_MIN) ? Q_MIN : q_t'(32'd0 - nq[31:0]);
    end
    return (nq > MAG_MAX) ? Q_MAX : q_t'(nq[31:0]);
  endfunction

  // Operand magnitudes enter stage zero; every later stage takes one step.
  always_comb begin
    logic [31:0] mag;
    st_d[0].d     = den_i[31] ? 32'd0 - den_i : den_i;
    st_d[0].bzero = (den_i == '0);
    st_d[0].pay   = pay_i;
    for (int l = 0; l < 3; l++) begin
      mag                = num_i[l][31] ? 32'd0 - num_i[l] : num_i[l];
      st_d[0].nq[l]      = {mag, {FRAC_BITS{1'b0}}};
      st_d[0].rem[l]     = '0;
      st_d[0].neg[l]     = num_i[l][31] ^ den_i[31];
      st_d[0].a_pos[l]   = !num_i[l][31] && (num_i[l] != '0);
      st_d[0].a_neg[l]   = num_i[l][31];
    end
    for (int k = 0; k < NB; k++) begin
      st_d[k+1] = div_step(st_q[k]);
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      quo_d[l] = div_fix(st_q[NB].nq[l], st_q[NB].neg[l], st_q[NB].a_pos[l],
                         st_q[NB].a_neg[l], st_q[NB].bzero);
    end
  end

  assign out_valid_o = ov_q;
  assign quo_o       = quo_q;
  assign pay_o       = pay_q;

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
      ov_q <= 1'b0;
    end else if (adv_i) begin
      sv_q <= {sv_q[NB-1:0], in_valid_i};
      ov_q <= sv_q[NB];
    end
  end

  // Stage payloads and the output register.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k <= NB; k++) begin
        st_q[k] <= st_d[k];
      end
      quo_q <= quo_d;
      pay_q <= st_q[NB].pay;
    end
  end

endmodule

[sv/prj_back.sv]
// Back part: projection, error and both Jacobian rows, with the row output register.
module prj_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [30:0]         fx_i,
  input  logic [30:0]         fy_i,
  input  prj_pkg::q_t         cx_i,
  input  prj_pkg::q_t         cy_i,
  input  prj_pkg::prj_mid_t   q_item_i,
  input  prj_pkg::prj_qstat_t q_stat_i,
  output logic                q_pop_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output prj_pkg::prj_row_t   m_row_o,
  output logic                m_last_o,
  output logic                m_depth_o
);
  import prj_pkg::*;

  typedef struct packed {
    qw_t p_pu, p_pv, p_fxz, p_fyz, p_xy, p_xx, p_yy, p_yzfx, p_xzfy;
    q_t  xz, yz;
    prj_dpay_t pay;
  } b1_t;

  typedef struct packed {
    q_t err_u, err_v, fxz, fyz, xy2, oxx, oyy, j06, j16, xz, yz;
    prj_dpay_t pay;
  } b2_t;

  typedef struct packed {
    qw_t p_u0, p_v0, p_j04, p_j05, p_j14, p_j15;
    qw_t [2:0] p_fr0;
    qw_t [2:0] p_fr1;
    q_t  err_u, err_v, fxz, fyz, j06, j16;
    prj_dpay_t pay;
  } b3_t;

  typedef struct packed {
    q_t u0, v0, j04, j05, j14, j15, j06, j16, j07, j18, err_u, err_v;
    q_t [2:0] fr0;
    q_t [2:0] fr1;
    prj_dpay_t pay;
  } b4_t;

  typedef struct packed {
    qw_t [2:0] p_ur;
    qw_t [2:0] p_vr;
    q_t  [2:0] fr0;
    q_t  [2:0] fr1;
    q_t  u0, v0, j04, j05, j14, j15, j06, j16, j07, j18, err_u, err_v;
    logic zpos;
  } b5_t;

  typedef struct packed {
    prj_row_t row0;
    prj_row_t row1;
    logic     zpos;
  } b6_t;

  logic      adv;
  logic [5:0] v_q;
  logic      row_q;
  logic      d_valid;
  q_t [2:0]  d_quo;
  prj_dpay_t d_pay, in_pay;
  q_t        fxs, fys;
  b1_t       s1_q, s1_d;
  b2_t       s2_q, s2_d;
  b3_t       s3_q, s3_d;
  b4_t       s4_q, s4_d;
  b5_t       s5_q, s5_d;
  b6_t       s6_q, s6_d;

  assign fxs = fsig(fx_i);
  assign fys = fsig(fy_i);

  // The back moves as one; the output register drains one item in two row transactions.
  assign adv     = !v_q[5] || (row_q && m_ready_i);
  assign q_pop_o = adv && !q_stat_i.empty;

  assign in_pay.rot   = q_item_i.rot;
  assign in_pay.obs_u = q_item_i.obs_u;
  assign in_pay.obs_v = q_item_i.obs_v;
  assign in_pay.zpos  = ($signed(q_item_i.pc_z) > 32'sd0);

  prj_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .in_valid_i  (!q_stat_i.empty),
    .num_i       ({ONE_Q, q_item_i.pc_y, q_item_i.pc_x}),
    .den_i       (q_item_i.pc_z),
    .pay_i       (in_pay),
    .out_valid_o (d_valid),
    .quo_o       (d_quo),
    .pay_o       (d_pay)
  );

  // Stage one: projection and squared-ratio products.
  always_comb begin
    s1_d.p_pu   = qprod(d_quo[0], fxs);
    s1_d.p_pv   = qprod(d_quo[1], fys);
    s1_d.p_fxz  = qprod(fxs, d_quo[2]);
    s1_d.p_fyz  = qprod(fys, d_quo[2]);
    s1_d.p_xy   = qprod(d_quo[0], d_quo[1]);
    s1_d.p_xx   = qprod(d_quo[0], d_quo[0]);
    s1_d.p_yy   = qprod(d_quo[1], d_quo[1]);
    s1_d.p_yzfx = qprod(d_quo[1], fxs);
    s1_d.p_xzfy = qprod(d_quo[0], fys);
    s1_d.xz     = d_quo[0];
    s1_d.yz     = d_quo[1];
    s1_d.pay    = d_pay;
  end

  // Stage two: errors and scaled terms.
  always_comb begin
    s2_d.err_u = sat(widen(s1_q.pay.obs_u) -
                     widen(sat(widen(qscale(s1_q.p_pu)) + widen(cx_i))));
    s2_d.err_v = sat(widen(s1_q.pay.obs_v) -
                     widen(sat(widen(qscale(s1_q.p_pv)) + widen(cy_i))));
    s2_d.fxz   = qscale(s1_q.p_fxz);
    s2_d.fyz   = qscale(s1_q.p_fyz);
    s2_d.xy2   = qscale(s1_q.p_xy);
    s2_d.oxx   = sat(ONE_W + widen(qscale(s1_q.p_xx)));
    s2_d.oyy   = sat(ONE_W + widen(qscale(s1_q.p_yy)));
    s2_d.j06   = qscale(s1_q.p_yzfx);
    s2_d.j16   = qneg(qscale(s1_q.p_xzfy));
    s2_d.xz    = s1_q.xz;
    s2_d.yz    = s1_q.yz;
    s2_d.pay   = s1_q.pay;
  end

  // Stage three: second-level products.
  always_comb begin
    s3_d.p_u0  = qprod(s2_q.fxz, s2_q.xz);
    s3_d.p_v0  = qprod(s2_q.fyz, s2_q.yz);
    s3_d.p_j04 = qprod(s2_q.xy2, fxs);
    s3_d.p_j05 = qprod(s2_q.oxx, fxs);
    s3_d.p_j14 = qprod(s2_q.oyy, fys);
    s3_d.p_j15 = qprod(s2_q.xy2, fys);
    for (int i = 0; i < 3; i++) begin
      s3_d.p_fr0[i] = qprod(s2_q.fxz, s2_q.pay.rot[i]);
      s3_d.p_fr1[i] = qprod(s2_q.fyz, s2_q.pay.rot[3+i]);
    end
    s3_d.err_u = s2_q.err_u;
    s3_d.err_v = s2_q.err_v;
    s3_d.fxz   = s2_q.fxz;
    s3_d.fyz   = s2_q.fyz;
    s3_d.j06   = s2_q.j06;
    s3_d.j16   = s2_q.j16;
    s3_d.pay   = s2_q.pay;
  end

  // Stage four: rescale and sign the pose terms.
  always_comb begin
    s4_d.u0    = qscale(s3_q.p_u0);
    s4_d.v0    = qscale(s3_q.p_v0);
    s4_d.j04   = qscale(s3_q.p_j04);
    s4_d.j05   = qneg(qscale(s3_q.p_j05));
    s4_d.j14   = qscale(s3_q.p_j14);
    s4_d.j15   = qneg(qscale(s3_q.p_j15));
    s4_d.j06   = s3_q.j06;
    s4_d.j16   = s3_q.j16;
    s4_d.j07   = qneg(s3_q.fxz);
    s4_d.j18   = qneg(s3_q.fyz);
    s4_d.err_u = s3_q.err_u;
    s4_d.err_v = s3_q.err_v;
    for (int i = 0; i < 3; i++) begin
      s4_d.fr0[i] = qscale(s3_q.p_fr0[i]);
      s4_d.fr1[i] = qscale(s3_q.p_fr1[i]);
    end
    s4_d.pay   = s3_q.pay;
  end

  // Stage five: projected point times the third rotation row.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s5_d.p_ur[i] = qprod(s4_q.u0, s4_q.pay.rot[6+i]);
      s5_d.p_vr[i] = qprod(s4_q.v0, s4_q.pay.rot[6+i]);
    end
    s5_d.fr0   = s4_q.fr0;
    s5_d.fr1   = s4_q.fr1;
    s5_d.u0    = s4_q.u0;
    s5_d.v0    = s4_q.v0;
    s5_d.j04   = s4_q.j04;
    s5_d.j05   = s4_q.j05;
    s5_d.j14   = s4_q.j14;
    s5_d.j15   = s4_q.j15;
    s5_d.j06   = s4_q.j06;
    s5_d.j16   = s4_q.j16;
    s5_d.j07   = s4_q.j07;
    s5_d.j18   = s4_q.j18;
    s5_d.err_u = s4_q.err_u;
    s5_d.err_v = s4_q.err_v;
    s5_d.zpos  = s4_q.pay.zpos;
  end

  // Stage six: assemble both rows; a point behind the camera saturates the Jacobians.
  always_comb begin
    s6_d.row0.error_value = s5_q.err_u;
    s6_d.row1.error_value = s5_q.err_v;
    s6_d.zpos             = s5_q.zpos;
    if (s5_q.zpos) begin
      s6_d.row0.jac_point_0 = sat(widen(qscale(s5_q.p_ur[0])) - widen(s5_q.fr0[0]));
      s6_d.row0.jac_point_1 = sat(widen(qscale(s5_q.p_ur[1])) - widen(s5_q.fr0[1]));
      s6_d.row0.jac_point_2 = sat(widen(qscale(s5_q.p_ur[2])) - widen(s5_q.fr0[2]));
      s6_d.row0.jac_pose_0  = s5_q.j04;
      s6_d.row0.jac_pose_1  = s5_q.j05;
      s6_d.row0.jac_pose_2  = s5_q.j06;
      s6_d.row0.jac_pose_3  = s5_q.j07;
      s6_d.row0.jac_pose_4  = '0;
      s6_d.row0.jac_pose_5  = s5_q.u0;
      s6_d.row1.jac_point_0 = sat(widen(qscale(s5_q.p_vr[0])) - widen(s5_q.fr1[0]));
      s6_d.row1.jac_point_1 = sat(widen(qscale(s5_q.p_vr[1])) - widen(s5_q.fr1[1]));
      s6_d.row1.jac_point_2 = sat(widen(qscale(s5_q.p_vr[2])) - widen(s5_q.fr1[2]));
      s6_d.row1.jac_pose_0  = s5_q.j14;
      s6_d.row1.jac_pose_1  = s5_q.j15;
      s6_d.row1.jac_pose_2  = s5_q.j16;
      s6_d.row1.jac_pose_3  = '0;
      s6_d.row1.jac_pose_4  = s5_q.j18;
      s6_d.row1.jac_pose_5  = s5_q.v0;
    end else begin
      s6_d.row0.jac_point_0 = Q_MAX;
      s6_d.row0.jac_point_1 = Q_MAX;
      s6_d.row0.jac_point_2 = Q_MAX;
      s6_d.row0.jac_pose_0  = Q_MAX;
      s6_d.row0.jac_pose_1  = Q_MAX;
      s6_d.row0.jac_pose_2  = Q_MAX;
      s6_d.row0.jac_pose_3  = Q_MAX;
      s6_d.row0.jac_pose_4  = Q_MAX;
      s6_d.row0.jac_pose_5  = Q_MAX;
      s6_d.row1.jac_point_0 = Q_MAX;
      s6_d.row1.jac_point_1 = Q_MAX;
      s6_d.row1.jac_point_2 = Q_MAX;
      s6_d.row1.jac_pose_0  = Q_MAX;
      s6_d.row1.jac_pose_1  = Q_MAX;
      s6_d.row1.jac_pose_2  = Q_MAX;
      s6_d.row1.jac_pose_3  = Q_MAX;
      s6_d.row1.jac_pose_4  = Q_MAX;
      s6_d.row1.jac_pose_5  = Q_MAX;
    end
  end

  assign m_valid_o = v_q[5];
  assign m_row_o   = row_q ? s6_q.row1 : s6_q.row0;
  assign m_last_o  = row_q;
  assign m_depth_o = s6_q.zpos;

  // Stage valid bits and the row selector of the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      row_q <= 1'b0;
    end else begin
      if (adv) begin
        v_q <= {v_q[4:0], d_valid};
      end
      if (v_q[5] && m_ready_i) begin
        row_q <= !row_q;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      s5_q <= s5_d;
      s6_q <= s6_d;
    end
  end

endmodule

[sv/pinhole_reprojection_jacobian.sv]
// Top level of the pinhole reprojection error and Jacobian block.
//
// Channel    Direction  Transaction
// s_axis     in         one pose, point and observed pixel per transaction
// m_axis     out        one result row per transaction, two rows per input
// APB        in/out     focal and principal-point registers
//
// The block accepts new inputs while earlier ones are still in flight; the output
// register sends the two rows of an item one after the other, which sets the rate.
// The path runs through four front stages, the queue, a divider of an operand
// stage and 48 one-bit stages plus its output register, and six back stages.
// Reset clears the pipelines and loads the register defaults; no clearing pass.
// A stall on m_axis fills the four-entry queue before s_axis_tready falls.
module pinhole_reprojection_jacobian (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // quat_x, quat_y, quat_z, quat_w, trans_x, trans_y, trans_z,
  // point_x, point_y, point_z, obs_u, obs_v (lowest bits first)
  input  logic [prj_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // error_value, jac_point_0..2, jac_pose_0..5 (lowest bits first)
  output logic [prj_pkg::OUT_W-1:0]   m_axis_tdata,
  output logic                        m_axis_tlast,
  // depth_positive
  output logic                        m_axis_tuser,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import prj_pkg::*;

  localparam logic [1:0] REG_FOCAL_X  = 2'd0;
  localparam logic [1:0] REG_FOCAL_Y  = 2'd1;
  localparam logic [1:0] REG_CENTER_X = 2'd2;
  localparam logic [1:0] REG_CENTER_Y = 2'd3;

  logic [30:0] fx_q, fy_q;
  q_t          cx_q, cy_q;
  logic        cfg_wr;
  prj_in_t     in_item;
  prj_mid_t    f_item, q_item;
  logic        f_valid, q_pop;
  prj_qstat_t  q_stat;
  prj_row_t    row;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q <= 31'd33554432;
      fy_q <= 31'd33554432;
      cx_q <= 32'sd20971520;
      cy_q <= 32'sd15728640;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FOCAL_X:  fx_q <= pwdata[30:0];
        REG_FOCAL_Y:  fy_q <= pwdata[30:0];
        REG_CENTER_X: cx_q <= pwdata;
        REG_CENTER_Y: cy_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_FOCAL_X:  prdata = {1'b0, fx_q};
      REG_FOCAL_Y:  prdata = {1'b0, fy_q};
      REG_CENTER_X: prdata = cx_q;
      REG_CENTER_Y: prdata = cy_q;
      default:      prdata = '0;
    endcase
  end

  assign in_item = s_axis_tdata;

  prj_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (f_valid),
    .out_ready_i (!q_stat.full),
    .out_item_o  (f_item)
  );

  prj_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_valid && !q_stat.full),
    .item_i (f_item),
    .pop_i  (q_pop),
    .item_o (q_item),
    .stat_o (q_stat)
  );

  prj_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fx_i      (fx_q),
    .fy_i      (fy_q),
    .cx_i      (cx_q),
    .cy_i      (cy_q),
    .q_item_i  (q_item),
    .q_stat_i  (q_stat),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_row_o   (row),
    .m_last_o  (m_axis_tlast),
    .m_depth_o (m_axis_tuser)
  );

  assign m_axis_tdata = row;

endmodule

[sv/prj_checker.sv]
// Port-level checker of the reprojection Jacobian block, bound to the top level.
`include "pinhole_reprojection_jacobian_macros.svh"

module prj_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [prj_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast,
  input logic                      m_axis_tuser
);
  import prj_pkg::*;

  // The vertical row follows the horizontal one at once.
  `PRJ_ASSERT_NEXT(a_row1_follows, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tlast, "vertical row did not follow the horizontal row")

  // Both rows of one item carry the same depth flag.
  `PRJ_ASSERT_NEXT(a_depth_same, m_axis_tvalid && m_axis_tready && !m_axis_tlast, $stable(m_axis_tuser), "depth flag differs between the two rows")

  // After the vertical row a new item starts with its horizontal row.
  `PRJ_ASSERT_NEXT(a_row0_next, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tlast, "row order broken after the vertical row")

  // A point behind the camera gives saturated Jacobians, checked on jac_point_0 and jac_pose_5.
  `PRJ_ASSERT_NOW(a_depth_sat, m_axis_tvalid && !m_axis_tuser, (m_axis_tdata[63:32] == 32'h7fff_ffff) && (m_axis_tdata[319:288] == 32'h7fff_ffff), "Jacobians not saturated for a non-positive depth")

  // A stalled output transaction stays offered.
  `PRJ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output valid dropped while stalled")

endmodule

bind pinhole_reprojection_jacobian prj_checker u_prj_checker (.*);
